// File: sv/srb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types, constants and helpers of the sequence reorder buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

   localparam int SEQ_W   = 32;
   localparam int TIME_W  = 64;
   localparam int KIND_W  = 8;
   localparam int TAG_W   = 16;
   localparam int CAP_W   = 5;
   localparam int FRAME_W = SEQ_W + TIME_W + KIND_W + TAG_W;

   // One frame; seq_num sits in the lowest bits
   typedef struct packed {
      logic [TAG_W-1:0]  payload_tag;
      logic [KIND_W-1:0] frame_kind;
      logic [TIME_W-1:0] time_stamp;
      logic [SEQ_W-1:0]  seq_num;
   } frame_type;

   // Command codes on req_tuser
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_INSERT,
      ST_FORCE_RD,
      ST_FORCE_EMIT,
      ST_DRAIN_RD,
      ST_DRAIN_CHK,
      ST_FINISH
   } state_type;

   // Wrap-around order: a comes before b
   function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return d[SEQ_W-1];
   endfunction

endpackage

// File: sv/srb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module srb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sequence_reorder_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Jitter/reorder buffer for numbered frames with a sorted frame store in RAM.
// ----------------------------------------------------------------------------
// Usage:
//  req_* takes commands: tuser = 0 pushes the frame in tdata, tuser = 1 flushes.
//  rsp_* returns released frames in order; tlast marks the final frame that
//  one command released. csr_* writes the capacity (0 = pass-through); a
//  write clears the store like a flush, is taken only between commands and
//  wins over a command offered in the same cycle.
// Sequence:
//  A command is taken in idle. A flush, a pass-through frame or a late frame
//  goes straight to the finish state; an in-order frame first releases the
//  held frames that follow it. Inserting a frame scans the held frames
//  through the RAM read port, a read and a check for each held frame, then
//  writes it; a forced release adds a read and an emit. Each further frame
//  released from the store needs a read, then a compare/emit. Each emitted
//  frame waits as pending and moves out on a later emit or at finish.
// Reset: store empty, not synchronized, capacity 8. No clearing pass.
// Stall: one output register plus one pending frame; when both are full the
//  sequencer waits, and req_tready stays low until the command is done.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer #(
   parameter int MAX_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   // tdata: seq_num[31:0], time_stamp[95:32], frame_kind[103:96],
   //        payload_tag[119:104]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,
   input  logic         req_tuser,   // cmd
   // tdata: out_seq[31:0], out_time[95:32], out_kind[103:96], out_tag[119:104]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,
   output logic         rsp_tlast,   // last_of_run
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_data     // capacity
);
   localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CW = $clog2(MAX_DEPTH + 1);

   srb_pkg::state_type             state_ff, state_in;
   logic [srb_pkg::CAP_W-1:0]      cap_ff, cap_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [srb_pkg::SEQ_W-1:0]      ne_ff, ne_in;
   logic                           sync_ff, sync_in;
   srb_pkg::frame_type             frame_ff, frame_in;
   logic [IW-1:0]                  idx_ff, idx_in;
   logic [IW-1:0]                  pos_ff, pos_in;
   logic                           found_ff, found_in;
   logic [IW-1:0]                  order_ff [MAX_DEPTH];
   logic [IW-1:0]                  order_in [MAX_DEPTH];
   logic                           pend_valid_ff, pend_valid_in;
   srb_pkg::frame_type             pend_ff, pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   srb_pkg::frame_type             rsp_ff, rsp_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [CW-1:0]                  cap_eff;
   logic                           can_emit;
   logic                           emit;
   srb_pkg::frame_type             emit_frame;
   logic                           do_insert, do_pop;
   logic [IW-1:0]                  ins_pos;
   logic [IW-1:0]                  rd_addr;
   logic [srb_pkg::FRAME_W-1:0]    rd_raw;
   srb_pkg::frame_type             rd_frame;
   srb_pkg::frame_type             req_frame;
   logic [CW-1:0]                  count_inc;

   assign req_frame = srb_pkg::frame_type'(req_tdata);
   assign rd_frame  = srb_pkg::frame_type'(rd_raw);
   assign cap_eff   = (int'(cap_ff) > MAX_DEPTH) ? CW'(MAX_DEPTH) : CW'(cap_ff);
   assign can_emit  = !pend_valid_ff || !rsp_valid_ff || rsp_tready;
   assign count_inc = count_ff + CW'(1);
   assign ins_pos   = found_ff ? pos_ff : count_ff[IW-1:0];

   // Frame store
   assign rd_addr = (state_ff == srb_pkg::ST_SCAN_RD || state_ff == srb_pkg::ST_SCAN_CHK)
                    ? order_ff[idx_ff] : order_ff[0];

   srb_ram #(
      .WIDTH (srb_pkg::FRAME_W),
      .DEPTH (MAX_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_insert),
      .wr_addr (order_ff[count_ff[IW-1:0]]),
      .wr_data (frame_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Port handshakes
   assign req_tready = (state_ff == srb_pkg::ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == srb_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      count_in      = count_ff;
      ne_in         = ne_ff;
      sync_in       = sync_ff;
      frame_in      = frame_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      emit          = 1'b0;
      emit_frame    = rd_frame;
      do_insert     = 1'b0;
      do_pop        = 1'b0;

      unique case (state_ff)
         srb_pkg::ST_IDLE: begin
            if (csr_valid) begin
               cap_in   = csr_data;
               count_in = '0;
               ne_in    = '0;
               sync_in  = 1'b0;
            end else if (req_tvalid) begin
               frame_in = req_frame;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = srb_pkg::ST_FINISH;
               if (req_tuser == srb_pkg::CMD_FLUSH) begin
                  count_in = '0;
                  ne_in    = '0;
                  sync_in  = 1'b0;
               end else if (cap_eff == '0) begin
                  emit       = 1'b1;
                  emit_frame = req_frame;
               end else if (sync_ff && req_frame.seq_num == ne_ff) begin
                  emit       = 1'b1;
                  emit_frame = req_frame;
                  ne_in      = ne_ff + srb_pkg::SEQ_W'(1);
                  state_in   = srb_pkg::ST_DRAIN_RD;
               end else if (sync_ff && srb_pkg::seq_before(req_frame.seq_num, ne_ff)) begin
                  state_in = srb_pkg::ST_FINISH;
               end else if (count_ff == '0) begin
                  state_in = srb_pkg::ST_INSERT;
               end else begin
                  state_in = srb_pkg::ST_SCAN_RD;
               end
            end
         end
         srb_pkg::ST_SCAN_RD: begin
            state_in = srb_pkg::ST_SCAN_CHK;
         end
         srb_pkg::ST_SCAN_CHK: begin
            // duplicate check over all held frames, first "not before" is the slot
            if (rd_frame.seq_num == frame_ff.seq_num) begin
               state_in = srb_pkg::ST_FINISH;
            end else begin
               if (!found_ff && !srb_pkg::seq_before(rd_frame.seq_num, frame_ff.seq_num)) begin
                  found_in = 1'b1;
                  pos_in   = idx_ff;
               end
               if (CW'(idx_ff) == count_ff - CW'(1)) begin
                  state_in = srb_pkg::ST_INSERT;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = srb_pkg::ST_SCAN_RD;
               end
            end
         end
         srb_pkg::ST_INSERT: begin
            do_insert = 1'b1;
            count_in  = count_inc;
            if (count_inc >= cap_eff) begin
               state_in = srb_pkg::ST_FORCE_RD;
            end else if (sync_ff) begin
               state_in = srb_pkg::ST_DRAIN_RD;
            end else begin
               state_in = srb_pkg::ST_FINISH;
            end
         end
         srb_pkg::ST_FORCE_RD: begin
            state_in = srb_pkg::ST_FORCE_EMIT;
         end
         srb_pkg::ST_FORCE_EMIT: begin
            // store full: oldest frame leaves and sets the expected number
            if (can_emit) begin
               emit     = 1'b1;
               do_pop   = 1'b1;
               count_in = count_ff - CW'(1);
               ne_in    = rd_frame.seq_num + srb_pkg::SEQ_W'(1);
               sync_in  = 1'b1;
               state_in = srb_pkg::ST_DRAIN_RD;
            end
         end
         srb_pkg::ST_DRAIN_RD: begin
            state_in = (count_ff == '0) ? srb_pkg::ST_FINISH : srb_pkg::ST_DRAIN_CHK;
         end
         srb_pkg::ST_DRAIN_CHK: begin
            if (rd_frame.seq_num != ne_ff) begin
               state_in = srb_pkg::ST_FINISH;
            end else if (can_emit) begin
               emit     = 1'b1;
               do_pop   = 1'b1;
               count_in = count_ff - CW'(1);
               ne_in    = ne_ff + srb_pkg::SEQ_W'(1);
               state_in = srb_pkg::ST_DRAIN_RD;
            end
         end
         srb_pkg::ST_FINISH: begin
            // last frame of the run goes out with tlast
            if (!pend_valid_ff) begin
               state_in = srb_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = srb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srb_pkg::ST_IDLE;
         end
      endcase

      // New result: previous pending frame moves to the output register
      if (emit) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = emit_frame;
      end
   end

   // Order list: slot pointers, [0,count) held in sorted order, rest free
   always_comb begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
         order_in[i] = order_ff[i];
         if (do_insert) begin
            if (IW'(i) == ins_pos) begin
               order_in[i] = order_ff[count_ff[IW-1:0]];
            end else if (IW'(i) > ins_pos && CW'(i) <= count_ff && i > 0) begin
               order_in[i] = order_ff[(i + MAX_DEPTH - 1) % MAX_DEPTH];
            end
         end else if (do_pop) begin
            if (CW'(i) + CW'(1) < count_ff) begin
               order_in[i] = order_ff[(i + 1) % MAX_DEPTH];
            end else if (CW'(i) + CW'(1) == count_ff) begin
               order_in[i] = order_ff[0];
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srb_pkg::ST_IDLE;
         cap_ff        <= srb_pkg::CAP_W'(8);
         count_ff      <= '0;
         ne_ff         <= '0;
         sync_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_DEPTH; i++) begin
            order_ff[i] <= IW'(i);
         end
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         count_ff      <= count_in;
         ne_ff         <= ne_in;
         sync_ff       <= sync_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int i = 0; i < MAX_DEPTH; i++) begin
            order_ff[i] <= order_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      found_ff    <= found_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DEPTH))
      else $error("held count beyond store depth");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == srb_pkg::ST_IDLE |-> !pend_valid_ff)
      else $error("pending frame left over between commands");

   a_idle_below_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == srb_pkg::ST_IDLE |-> (count_ff < cap_eff || count_ff == '0))
      else $error("store at capacity between commands");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      do_pop |-> count_ff != '0)
      else $error("pop from empty store");
`endif

endmodule

// File: tb/sequence_reorder_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_tb
// Drives push and flush commands and capacity writes into the reorder buffer
// and checks every released frame, in order, against a behavioral predictor.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_tb;

   localparam int DEPTH = 16;

   typedef struct {
      logic [srb_pkg::SEQ_W-1:0]  seq;
      logic [srb_pkg::TIME_W-1:0] ts;
      logic [srb_pkg::KIND_W-1:0] kind;
      logic [srb_pkg::TAG_W-1:0]  tag;
      logic                       last;
   } release_type;

   int error_count = 0;

   // Print one mismatch line and count it
   task automatic report(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Predictor of the frame store plus queue of expected releases
   class release_board;
      srb_pkg::frame_type held[DEPTH];
      int                 held_count;
      logic [31:0]        next_seq;
      bit                 synced;
      int                 capacity;
      release_type        pending[$];

      function new();
         capacity = 8;
         clear();
      endfunction

      function void clear();
         held_count = 0;
         next_seq   = 0;
         synced     = 0;
      endfunction

      function void set_capacity(input logic [4:0] value);
         clear();
         capacity = value;
      endfunction

      function bit earlier(input logic [31:0] a, input logic [31:0] b);
         logic [31:0] d;
         d = a - b;
         return d[31];
      endfunction

      function void release_frame(input srb_pkg::frame_type f);
         release_type r;
         r.seq = f.seq_num; r.ts = f.time_stamp;
         r.kind = f.frame_kind; r.tag = f.payload_tag; r.last = 0;
         pending = {pending, r};
      endfunction

      function void pop_oldest();
         for (int i = 1; i < held_count; i++) held[i-1] = held[i];
         held_count--;
      endfunction

      function void drain();
         while (held_count > 0 && held[0].seq_num == next_seq) begin
            release_frame(held[0]);
            pop_oldest();
            next_seq++;
         end
      endfunction

      // Note an accepted command and queue the frames it releases
      function void note_command(input logic cmd, input srb_pkg::frame_type f);
         int cap, before_n, pos;
         cap = capacity > DEPTH ? DEPTH : capacity;
         before_n = pending.size();
         if (cmd == srb_pkg::CMD_FLUSH) begin
            clear();
            return;
         end
         if (cap == 0) begin
            release_frame(f);
         end else if (synced && f.seq_num == next_seq) begin
            release_frame(f);
            next_seq++;
            drain();
         end else if (synced && earlier(f.seq_num, next_seq)) begin
            return;
         end else begin
            for (int i = 0; i < held_count; i++)
               if (held[i].seq_num == f.seq_num) return;
            pos = held_count;
            for (int i = 0; i < held_count; i++)
               if (!earlier(held[i].seq_num, f.seq_num)) begin
                  pos = i;
                  break;
               end
            for (int i = held_count; i > pos; i--) held[i] = held[i-1];
            held[pos] = f;
            held_count++;
            while (held_count > 0 && held_count >= cap) begin
               release_frame(held[0]);
               next_seq = held[0].seq_num + 1;
               synced   = 1;
               pop_oldest();
            end
            if (synced) drain();
         end
         if (pending.size() > before_n) pending[pending.size()-1].last = 1;
      endfunction

      // Compare one released frame with the oldest expectation
      task check_release(input logic [119:0] data, input logic last);
         release_type        e;
         srb_pkg::frame_type g;
         g = data;
         if (pending.size() == 0) begin
            report($sformatf("unexpected frame seq %h", g.seq_num));
            return;
         end
         e = pending[0];
         pending.delete(0);
         if (g.seq_num !== e.seq)
            report($sformatf("seq %h, want %h", g.seq_num, e.seq));
         if (g.time_stamp !== e.ts)
            report($sformatf("time %h, want %h", g.time_stamp, e.ts));
         if (g.frame_kind !== e.kind)
            report($sformatf("kind %h, want %h", g.frame_kind, e.kind));
         if (g.payload_tag !== e.tag)
            report($sformatf("tag %h, want %h", g.payload_tag, e.tag));
         if (last !== e.last)
            report($sformatf("last %b, want %b (seq %h)", last, e.last, e.seq));
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [119:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [4:0]   csr_data = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   release_board board = new();

   always #2 clock = ~clock;

   sequence_reorder_buffer #(.MAX_DEPTH(DEPTH)) uut (.*);

   // Result side: sample at rising edge, stall at falling edge
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_release(rsp_tdata, rsp_tlast);

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Send one command; hold it until the transfer, valid drops on idle
   task automatic send(input logic cmd, input srb_pkg::frame_type f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1; req_tuser <= cmd; req_tdata <= f;
      do @(posedge clock); while (!req_tready);
      board.note_command(cmd, f);
      @(negedge clock);
   endtask

   task automatic push(input logic [31:0] s);
      srb_pkg::frame_type f;
      f.seq_num = s;
      f.time_stamp = {$urandom, $urandom};
      f.frame_kind = srb_pkg::KIND_W'($urandom);
      f.payload_tag = srb_pkg::TAG_W'($urandom);
      send(srb_pkg::CMD_PUSH, f);
   endtask

   // Drop valid, wait for all expected frames, then for the block to settle
   task automatic settle();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [4:0] value);
      settle();
      csr_valid <= 1; csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_capacity(value);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Random burst: mostly nearby windows with jitter, some noise and flushes
   task automatic random_burst(input int count);
      logic [31:0] base;
      int r;
      base = $urandom;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 3) begin
            send(srb_pkg::CMD_FLUSH, srb_pkg::frame_type'(
                 srb_pkg::FRAME_W'({$urandom, $urandom, $urandom, $urandom})));
         end else if (r < 8) begin
            push($urandom);
         end else begin
            push(base + $urandom_range(7) - 2);
            if ($urandom_range(2) != 0) base++;
         end
      end
   endtask

   initial begin
      srb_pkg::frame_type f;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: reset capacity, in-order, reordered, late, duplicate, wrap
      push(32'd5); push(32'd3); push(32'd4); push(32'd9); push(32'd1);
      push(32'd2); push(32'd6); push(32'd7); push(32'd8); push(32'd10);
      push(32'd2); push(32'd11); push(32'd11);
      f = '1;
      send(srb_pkg::CMD_PUSH, f);
      send(srb_pkg::CMD_FLUSH, '0);
      write_capacity(5'd0);
      f = '0;
      send(srb_pkg::CMD_PUSH, f);
      f = '1;
      send(srb_pkg::CMD_PUSH, f);
      write_capacity(5'd2);
      push(32'hFFFF_FFFE); push(32'h0000_0001); push(32'hFFFF_FFFF);
      push(32'h0000_0000); push(32'h0000_0002);
      write_capacity(5'd31);
      for (int i = 0; i < 17; i++) push(32'd100 - i);

      // Random phases across capacities and idling profiles
      send_idle_pct = 0;  stall_pct = 0;
      write_capacity(5'd1);  random_burst(35);
      send_idle_pct = 81; stall_pct = 0;
      write_capacity(5'd4);  random_burst(40);
      settle();
      send_idle_pct = 0;  stall_pct = 81;
      write_capacity(5'd16); random_burst(45);
      send_idle_pct = 6;  stall_pct = 6;
      write_capacity(5'd0);  random_burst(25);
      write_capacity(5'd8);  random_burst(40);
      send_idle_pct = 0;  stall_pct = 0;
      write_capacity(5'd3);  random_burst(45);

      settle();
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule
